FILE: rtl/ebsd_pkg.sv
package ebsd_pkg;

   // Field and datapath widths
   localparam int unsigned DataW = 32;
   localparam int unsigned TsW   = 24;
   localparam int unsigned DtW   = 23;
   localparam int unsigned CapW  = 40;
   localparam int unsigned CsrIdxW = 1;

   // Pipelined square root and divider depths
   localparam int unsigned SqrtSteps = 32;
   localparam int unsigned DivSteps  = 32;

   // Frame-delta step: (frame_delta_ms + 500) / 1000, done as ((x + 500) >> 3) / 125,
   // with the divide by 125 as a multiply by ceil(2^37 / 125) and a shift by 37
   localparam logic [32:0] FdRound    = 33'd500;
   localparam logic [30:0] FdRecip    = 31'd1099511628;

   // Step constants and register reset values
   localparam logic [DtW-1:0]   DtPrecise    = 23'd655;
   localparam logic [DtW-1:0]   DtReset      = 23'd1049;
   localparam logic [DataW-1:0] DensityReset = 32'h0001_0000;
   localparam logic [CapW-1:0]  Cap40        = {CapW{1'b1}};
   localparam logic [63:0]      Half64       = 64'h8000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_FRAME_DELTA   = 1'b0,
      CSR_SPACE_DENSITY = 1'b1
   } csr_idx_type;

   // Body data that rides along the square-root and divider pipelines
   typedef struct packed {
      logic [2:0][DataW-1:0] pos;
      logic [2:0][DataW-1:0] vel;
      logic [DataW-1:0]      dts;
      logic [DtW-1:0]        dt;
      logic [CapW-1:0]       c1;
      logic [DataW-1:0]      speed;
      logic                  kill;
      logic                  still;
   } side_type;

   // Magnitude of a signed 32-bit value; the most negative value maps to 2^31
   function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] v);
      return v[DataW-1] ? (~v + 32'd1) : v;
   endfunction

   // v +/- t, saturated to the signed 32-bit range
   function automatic logic [DataW-1:0] sat_add(input logic [DataW-1:0] v,
                                                input logic neg,
                                                input logic [47:0] t);
      logic [49:0] ve;
      logic [49:0] te;
      logic [49:0] s;
      ve = {{18{v[DataW-1]}}, v};
      te = {2'b00, t};
      s  = neg ? (ve - te) : (ve + te);
      if ((&s[49:31]) || !(|s[49:31])) begin
         return s[31:0];
      end
      return s[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

endpackage

FILE: rtl/ebsd_if.sv
interface ebsd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] vel_z;
   logic signed [31:0] acc_x;
   logic signed [31:0] acc_y;
   logic signed [31:0] acc_z;
   logic        [31:0] drag_coeff;
   logic        [23:0] time_scale;
   logic               precise;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   acc_x, acc_y, acc_z, drag_coeff, time_scale, precise,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 acc_x, acc_y, acc_z, drag_coeff, time_scale, precise,
                 output ready);
endinterface

interface ebsd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_pos_x;
   logic signed [31:0] new_pos_y;
   logic signed [31:0] new_pos_z;
   logic signed [31:0] new_vel_x;
   logic signed [31:0] new_vel_y;
   logic signed [31:0] new_vel_z;

   modport source (output valid, new_pos_x, new_pos_y, new_pos_z,
                   new_vel_x, new_vel_y, new_vel_z, input ready);
   modport sink (input valid, new_pos_x, new_pos_y, new_pos_z,
                 new_vel_x, new_vel_y, new_vel_z, output ready);
endinterface

FILE: rtl/ebsd_isqrt.sv
module ebsd_isqrt import ebsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [63:0]      in_rad,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [DataW-1:0] out_root,
   output side_type         out_side
);

   logic [63:0] x_ff   [SqrtSteps];
   logic [63:0] res_ff [SqrtSteps];
   logic        vld_ff [SqrtSteps];
   side_type    side_ff[SqrtSteps];

   logic [63:0] x_in   [SqrtSteps];
   logic [63:0] res_in [SqrtSteps];
   logic        vld_in [SqrtSteps];
   side_type    side_in[SqrtSteps];

   // One result bit per stage, trial bit walking down two places a stage
   always_comb begin
      logic [63:0] x_src;
      logic [63:0] res_src;
      logic [63:0] step_bit;
      logic [63:0] trial;
      for (int s = 0; s < SqrtSteps; s++) begin
         if (s == 0) begin
            x_src      = in_rad;
            res_src    = '0;
            vld_in[s]  = in_valid;
            side_in[s] = in_side;
         end else begin
            x_src      = x_ff[s-1];
            res_src    = res_ff[s-1];
            vld_in[s]  = vld_ff[s-1];
            side_in[s] = side_ff[s-1];
         end
         step_bit = 64'd1 << (62 - 2 * s);
         trial    = res_src + step_bit;
         if (x_src >= trial) begin
            x_in[s]   = x_src - trial;
            res_in[s] = (res_src >> 1) + step_bit;
         end else begin
            x_in[s]   = x_src;
            res_in[s] = res_src >> 1;
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SqrtSteps; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         for (int s = 0; s < SqrtSteps; s++) vld_ff[s] <= vld_in[s];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < SqrtSteps; s++) begin
            x_ff[s]    <= x_in[s];
            res_ff[s]  <= res_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = vld_ff[SqrtSteps-1];
   assign out_root  = res_ff[SqrtSteps-1][DataW-1:0];
   assign out_side  = side_ff[SqrtSteps-1];

endmodule

FILE: rtl/ebsd_div.sv
module ebsd_div import ebsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [2:0][63:0]      in_num,
   input  side_type              in_side,
   output logic                  out_valid,
   output logic [2:0][DataW-1:0] out_quo,
   output side_type              out_side
);

   // Divisor is the speed carried in the side data; every quotient fits 32 bits
   logic [2:0][63:0] acc_ff [DivSteps];
   logic             vld_ff [DivSteps];
   side_type         side_ff[DivSteps];

   logic [2:0][63:0] acc_in [DivSteps];
   logic             vld_in [DivSteps];
   side_type         side_in[DivSteps];

   // Restoring division, one quotient bit per stage in each lane
   always_comb begin
      logic [2:0][63:0] acc_src;
      logic [32:0]      den;
      logic [32:0]      rem;
      logic             ge;
      for (int s = 0; s < DivSteps; s++) begin
         if (s == 0) begin
            acc_src    = in_num;
            vld_in[s]  = in_valid;
            side_in[s] = in_side;
         end else begin
            acc_src    = acc_ff[s-1];
            vld_in[s]  = vld_ff[s-1];
            side_in[s] = side_ff[s-1];
         end
         den = {1'b0, side_in[s].speed};
         for (int l = 0; l < 3; l++) begin
            rem = {acc_src[l][63:32], acc_src[l][31]};
            ge  = (rem >= den);
            if (ge) rem = rem - den;
            acc_in[s][l] = {rem[31:0], acc_src[l][30:0], ge};
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DivSteps; s++) vld_ff[s] <= 1'b0;
      end else if (advance) begin
         for (int s = 0; s < DivSteps; s++) vld_ff[s] <= vld_in[s];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DivSteps; s++) begin
            acc_ff[s]  <= acc_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid  = vld_ff[DivSteps-1];
   assign out_quo[0] = acc_ff[DivSteps-1][0][31:0];
   assign out_quo[1] = acc_ff[DivSteps-1][1][31:0];
   assign out_quo[2] = acc_ff[DivSteps-1][2][31:0];
   assign out_side   = side_ff[DivSteps-1];

endmodule

FILE: rtl/euler_body_step_with_drag.sv
// Throughput: one body per cycle; the whole pipeline holds while a result waits.
// A write to frame_delta_ms recomputes the step with a reciprocal multiply in the
// write cycle; it never stalls the input.
// Reset (synchronous, active high) empties the pipeline and loads the register defaults.
module euler_body_step_with_drag import ebsd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_idx,
   input  logic [DataW-1:0]   csr_wdata,
   ebsd_req_if.sink           req_chan,
   ebsd_rsp_if.source         rsp_chan
);

   logic advance;
   logic take;

   // ---------------- configuration ----------------
   logic [DataW-1:0] dens_ff;
   logic [DtW-1:0]   dt_cfg_ff;
   logic [32:0]      fd_sum;
   logic [60:0]      fd_prod;

   // Round the frame delta, drop three bits, then divide by 125 by reciprocal
   always_comb begin
      fd_sum  = {1'b0, csr_wdata} + FdRound;
      fd_prod = fd_sum[32:3] * FdRecip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dens_ff   <= DensityReset;
         dt_cfg_ff <= DtReset;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_FRAME_DELTA: begin
               dt_cfg_ff <= fd_prod[59:37];
            end
            CSR_SPACE_DENSITY: begin
               dens_ff <= csr_wdata;
            end
            default: begin
               dens_ff <= dens_ff;
            end
         endcase
      end
   end

   // ---------------- handshake ----------------
   logic out_vld_ff;

   assign advance        = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign take           = req_chan.valid;

   // ---------------- stage registers ----------------
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic s8_vld_ff, s9_vld_ff, s10_vld_ff, s11_vld_ff, s12_vld_ff, s13_vld_ff;
   logic s14_vld_ff, s15_vld_ff, s16_vld_ff;

   side_type s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff, s5_side_ff, s6_side_ff;
   side_type s8_side_ff, s9_side_ff, s10_side_ff, s11_side_ff, s12_side_ff;
   side_type s13_side_ff, s14_side_ff, s15_side_ff, s16_side_ff;
   side_type s1_side_in, s4_side_in, s11_side_in, s14_side_in, s16_side_in;
   side_type s2_side_in;

   logic [2:0][DataW-1:0] s1_acc_ff;
   logic [46:0]           s1_dtsp_ff;
   logic [63:0]           s1_c1p_ff;
   logic [2:0][DataW-1:0] s2_amag_ff;
   logic [2:0]            s2_aneg_ff;
   logic [2:0][63:0]      s3_prod_ff;
   logic [2:0]            s3_aneg_ff;
   logic [2:0][63:0]      s5_sq_ff;
   logic [63:0]           s6_sum_ff;
   logic [55:0]           s8_p_ff;
   logic [CapW-1:0]       s9_p15_ff;
   logic [59:0]           s10_pl_ff;
   logic [59:0]           s10_ph_ff;
   logic [62:0]           s12_p3_ff;
   logic [CapW-1:0]       s13_dv_ff;
   logic [2:0][63:0]      s14_num_ff;
   logic [2:0][DataW-1:0] s15_m2_ff;
   logic [2:0]            s15_neg_ff;
   logic [2:0][63:0]      s16_pp_ff;
   logic [2:0]            s16_neg_ff;
   logic [2:0][DataW-1:0] out_pos_ff;
   logic [2:0][DataW-1:0] out_vel_ff;

   logic [DtW-1:0]   dt_sel;
   logic [47:0]      dts_sum;
   logic [63:0]      c1_sum;
   logic [CapW-1:0]  c1_val;
   logic [55:0]      p15_sum;
   logic [79:0]      c2_sum;
   logic [CapW-1:0]  c2_val;
   logic [63:0]      dv_sum;
   logic [CapW-1:0]  dv_val;

   logic             q1_vld, q2_vld, d_vld;
   logic [DataW-1:0] q1_root, q2_root;
   side_type         q1_side, q1_side_mod, q2_side, d_side;
   logic [2:0][DataW-1:0] d_quo;

   // Pick the step and capture the body
   always_comb begin
      dt_sel = req_chan.precise ? DtPrecise : dt_cfg_ff;
      s1_side_in        = '0;
      s1_side_in.pos[0] = req_chan.pos_x;
      s1_side_in.pos[1] = req_chan.pos_y;
      s1_side_in.pos[2] = req_chan.pos_z;
      s1_side_in.vel[0] = req_chan.vel_x;
      s1_side_in.vel[1] = req_chan.vel_y;
      s1_side_in.vel[2] = req_chan.vel_z;
      s1_side_in.dt     = dt_sel;
   end

   // Round the scaled step and the density-friction product
   always_comb begin
      dts_sum = {1'b0, s1_dtsp_ff} + Half64[47:0];
      c1_sum  = s1_c1p_ff + Half64;
      c1_val  = (|c1_sum[63:56]) ? Cap40 : c1_sum[55:16];
      s2_side_in     = s1_side_ff;
      s2_side_in.dts = dts_sum[47:16];
      s2_side_in.c1  = c1_val;
   end

   // Add the rounded acceleration term to the velocity
   always_comb begin
      s4_side_in = s3_side_ff;
      for (int i = 0; i < 3; i++) begin
         s4_side_in.vel[i] = sat_add(s3_side_ff.vel[i], s3_aneg_ff[i],
                                     48'((s3_prod_ff[i] + Half64) >> 16));
      end
   end

   // Attach the speed for the second root
   always_comb begin
      q1_side_mod       = q1_side;
      q1_side_mod.speed = q1_root;
   end

   // Round speed^1.5, then finish the drag products
   always_comb begin
      p15_sum = s8_p_ff + Half64[55:0];
      c2_sum  = {20'd0, s10_pl_ff} + {s10_ph_ff, 20'd0} + {16'd0, Half64};
      c2_val  = (|c2_sum[79:56]) ? Cap40 : c2_sum[55:16];
      dv_sum  = {1'b0, s12_p3_ff} + Half64;
      dv_val  = (|dv_sum[63:56]) ? Cap40 : dv_sum[55:16];
      s11_side_in    = s10_side_ff;
      s11_side_in.c1 = c2_val;
   end

   // Decide zeroing and form the drag numerators
   always_comb begin
      s14_side_in       = s13_side_ff;
      s14_side_in.still = (s13_side_ff.speed == '0);
      s14_side_in.kill  = (s13_side_ff.speed != '0) &&
                          ({8'd0, s13_side_ff.speed} <= s13_dv_ff);
   end

   // Rebuild the signed velocity after drag
   always_comb begin
      s16_side_in = s15_side_ff;
      for (int i = 0; i < 3; i++) begin
         s16_side_in.vel[i] = s15_neg_ff[i] ? (~s15_m2_ff[i] + 32'd1) : s15_m2_ff[i];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         s8_vld_ff  <= 1'b0;
         s9_vld_ff  <= 1'b0;
         s10_vld_ff <= 1'b0;
         s11_vld_ff <= 1'b0;
         s12_vld_ff <= 1'b0;
         s13_vld_ff <= 1'b0;
         s14_vld_ff <= 1'b0;
         s15_vld_ff <= 1'b0;
         s16_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff  <= take;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s5_vld_ff  <= s4_vld_ff;
         s6_vld_ff  <= s5_vld_ff;
         s8_vld_ff  <= q2_vld;
         s9_vld_ff  <= s8_vld_ff;
         s10_vld_ff <= s9_vld_ff;
         s11_vld_ff <= s10_vld_ff;
         s12_vld_ff <= s11_vld_ff;
         s13_vld_ff <= s12_vld_ff;
         s14_vld_ff <= s13_vld_ff;
         s15_vld_ff <= d_vld;
         s16_vld_ff <= s15_vld_ff;
         out_vld_ff <= s16_vld_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         // capture body, multiply step by time scale and density by friction
         s1_side_ff   <= s1_side_in;
         s1_acc_ff[0] <= req_chan.acc_x;
         s1_acc_ff[1] <= req_chan.acc_y;
         s1_acc_ff[2] <= req_chan.acc_z;
         s1_dtsp_ff   <= dt_sel * req_chan.time_scale;
         s1_c1p_ff    <= dens_ff * req_chan.drag_coeff;

         // round products, split acceleration into sign and magnitude
         s2_side_ff <= s2_side_in;
         for (int i = 0; i < 3; i++) begin
            s2_amag_ff[i] <= mag32(s1_acc_ff[i]);
            s2_aneg_ff[i] <= s1_acc_ff[i][DataW-1];
         end

         // acceleration times scaled step
         s3_side_ff <= s2_side_ff;
         s3_aneg_ff <= s2_aneg_ff;
         for (int i = 0; i < 3; i++) s3_prod_ff[i] <= s2_amag_ff[i] * s2_side_ff.dts;

         s4_side_ff <= s4_side_in;

         // squares of the new velocity
         s5_side_ff <= s4_side_ff;
         for (int i = 0; i < 3; i++) s5_sq_ff[i] <= mag32(s4_side_ff.vel[i]) *
                                                     mag32(s4_side_ff.vel[i]);

         s6_side_ff <= s5_side_ff;
         s6_sum_ff  <= s5_sq_ff[0] + s5_sq_ff[1] + s5_sq_ff[2];

         // speed times root of speed
         s8_side_ff <= q2_side;
         s8_p_ff    <= q2_side.speed * q2_root[23:0];

         s9_side_ff <= s8_side_ff;
         s9_p15_ff  <= p15_sum[55:16];

         // split the friction-power product into two halves
         s10_side_ff <= s9_side_ff;
         s10_pl_ff   <= s9_side_ff.c1 * s9_p15_ff[19:0];
         s10_ph_ff   <= s9_side_ff.c1 * s9_p15_ff[39:20];

         s11_side_ff <= s11_side_in;

         // times the unscaled step
         s12_side_ff <= s11_side_ff;
         s12_p3_ff   <= s11_side_ff.c1 * s11_side_ff.dt;

         s13_side_ff <= s12_side_ff;
         s13_dv_ff   <= dv_val;

         // numerators of the drag share per component
         s14_side_ff <= s14_side_in;
         for (int i = 0; i < 3; i++) s14_num_ff[i] <= mag32(s13_side_ff.vel[i]) *
                                                       s13_dv_ff[31:0];

         // reduce magnitudes toward zero
         s15_side_ff <= d_side;
         for (int i = 0; i < 3; i++) begin
            s15_neg_ff[i] <= d_side.vel[i][DataW-1];
            s15_m2_ff[i]  <= (d_side.kill || d_side.still) ? '0 :
                             (mag32(d_side.vel[i]) - d_quo[i]);
         end

         // velocity times scaled step
         s16_side_ff <= s16_side_in;
         s16_neg_ff  <= s15_neg_ff;
         for (int i = 0; i < 3; i++) s16_pp_ff[i] <= s15_m2_ff[i] * s15_side_ff.dts;

         // new position and final velocity
         for (int i = 0; i < 3; i++) begin
            out_pos_ff[i] <= sat_add(s16_side_ff.pos[i], s16_neg_ff[i],
                                     48'((s16_pp_ff[i] + Half64) >> 16));
            out_vel_ff[i] <= s16_side_ff.vel[i];
         end
      end
   end

   // ---------------- speed and speed root ----------------
   ebsd_isqrt u_speed_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s6_vld_ff),
      .in_rad    (s6_sum_ff),
      .in_side   (s6_side_ff),
      .out_valid (q1_vld),
      .out_root  (q1_root),
      .out_side  (q1_side)
   );

   ebsd_isqrt u_power_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (q1_vld),
      .in_rad    ({16'd0, q1_root, 16'd0}),
      .in_side   (q1_side_mod),
      .out_valid (q2_vld),
      .out_root  (q2_root),
      .out_side  (q2_side)
   );

   // ---------------- drag share division ----------------
   ebsd_div u_drag_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s14_vld_ff),
      .in_num    (s14_num_ff),
      .in_side   (s14_side_ff),
      .out_valid (d_vld),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   // ---------------- result ----------------
   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.new_pos_x = out_pos_ff[0];
   assign rsp_chan.new_pos_y = out_pos_ff[1];
   assign rsp_chan.new_pos_z = out_pos_ff[2];
   assign rsp_chan.new_vel_x = out_vel_ff[0];
   assign rsp_chan.new_vel_y = out_vel_ff[1];
   assign rsp_chan.new_vel_z = out_vel_ff[2];

   // ---------------- assertions ----------------
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(out_pos_ff) && $stable(out_vel_ff))
      else $error("waiting result changed before its transfer");

   a_kill_zero: assert property (@(posedge clock) disable iff (reset)
      s16_vld_ff && s16_side_ff.kill |-> (s16_side_ff.vel == '0))
      else $error("drag kill left a nonzero velocity");

   a_zero_speed: assert property (@(posedge clock) disable iff (reset)
      q1_vld && (q1_root == '0) |-> (q1_side.vel == '0))
      else $error("zero speed with a nonzero velocity");

   a_drag_share: assert property (@(posedge clock) disable iff (reset)
      d_vld && !d_side.kill && !d_side.still |->
         (d_quo[0] <= mag32(d_side.vel[0])) && (d_quo[1] <= mag32(d_side.vel[1])) &&
         (d_quo[2] <= mag32(d_side.vel[2])))
      else $error("drag share exceeds velocity magnitude");

endmodule
